[rtl/hs3d_pkg.sv]
package hs3d_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_DIM_DEF    = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field and register widths
	localparam int DIM_W       = 6;
	localparam int ALPHA_W     = 16;
	localparam int ALPHA_BIT_W = $clog2(ALPHA_W);
	localparam int STEPS_W     = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int ADDR_W      = 15;
	localparam int FIELD_W     = 32;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEPS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 3'd4;

	// Input opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_SETUP,
		ST_NEXT,
		ST_FETCH,
		ST_LAST,
		ST_MINIT,
		ST_MUL,
		ST_RND,
		ST_FIN,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		ALU_HOLD,
		ALU_CENTRE,
		ALU_ADD,
		ALU_MINIT,
		ALU_MUL,
		ALU_RND
	} alu_op_t;

	typedef struct packed {
		alu_op_t                 op;
		logic [ALPHA_BIT_W-1:0] bit_idx;
	} alu_ctl_t;

	typedef struct packed {
		logic re;
		logic rd_b;
		logic we_a;
		logic we_b;
		logic wsel_alu;
	} mem_ctl_t;

	typedef struct packed {
		logic load;
		logic kind;
		logic zero;
	} out_ctl_t;

endpackage

[rtl/heat_stencil_3d_sweeper.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall  | opcode, cell_address, cell_value
// out      | out_valid / out_stall| result_kind, read_value
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Write and unknown items are finished when taken; a read also waits for the
// output register. A run sweeps the (W-1)(H-1)(D-1) cells time_steps times, the work
// per cell set by seven reads on the single grid read port
// and the 16-step shift-add multiply in the shared arithmetic unit.
// Reset clears control and configuration; grid contents are undefined until written.
// A result waiting in the output register does not stop the next item being taken.
module heat_stencil_3d_sweeper #(
	parameter int MAX_DIM    = hs3d_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = hs3d_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hs3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hs3d_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [hs3d_pkg::ADDR_W-1:0]          cell_address,
	input  logic signed [hs3d_pkg::FIELD_W-1:0]  cell_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 result_kind,
	output logic signed [hs3d_pkg::FIELD_W-1:0]  read_value
);

	localparam int CELLS   = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW      = $clog2(CELLS);
	localparam int XW      = ((AW > hs3d_pkg::ADDR_W) ? AW : hs3d_pkg::ADDR_W) + 1;
	localparam int MW      = (VALUE_BITS > hs3d_pkg::FIELD_W) ? VALUE_BITS : hs3d_pkg::FIELD_W;
	localparam int DW      = hs3d_pkg::DIM_W;
	localparam int DIM_CAP = (MAX_DIM < 63) ? MAX_DIM : 63;

	logic [hs3d_pkg::ALPHA_W-1:0] alpha_q;
	logic [hs3d_pkg::STEPS_W-1:0] time_steps_q;
	logic [DW-1:0]                grid_width_q;
	logic [DW-1:0]                grid_height_q;
	logic [DW-1:0]                grid_depth_q;
	logic [DW-1:0]                dim_w, dim_h, dim_d;

	logic [XW-1:0]                addr_x;
	logic                         addr_ok;
	logic [AW-1:0]                item_addr;
	logic signed [MW-1:0]         wr_ext;
	logic                         wr_fits;
	logic [VALUE_BITS-1:0]        wr_val;
	logic signed [VALUE_BITS-1:0] rdata;
	logic signed [MW-1:0]         rd_ext;
	logic                         rd_fits;
	logic [hs3d_pkg::FIELD_W-1:0] rd_sat;
	logic [VALUE_BITS-1:0]        alu_result;
	logic [VALUE_BITS-1:0]        mem_wdata;
	logic [AW-1:0]                raddr, waddr;
	logic                         out_free;

	logic                         out_valid_q;
	logic                         result_kind_q;
	logic [hs3d_pkg::FIELD_W-1:0] read_value_q;

	hs3d_pkg::mem_ctl_t mem_ctl;
	hs3d_pkg::alu_ctl_t alu_ctl;
	hs3d_pkg::out_ctl_t out_ctl;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		if (v < DW'(2)) begin
			r = DW'(2);
		end else if (v > DW'(DIM_CAP)) begin
			r = DW'(DIM_CAP);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q       <= '0;
			time_steps_q  <= '0;
			grid_width_q  <= DW'(32);
			grid_height_q <= DW'(32);
			grid_depth_q  <= DW'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				hs3d_pkg::CFG_ALPHA:       alpha_q       <= cfg_data;
				hs3d_pkg::CFG_TIME_STEPS:  time_steps_q  <= cfg_data;
				hs3d_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[DW-1:0];
				hs3d_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data[DW-1:0];
				hs3d_pkg::CFG_GRID_DEPTH:  grid_depth_q  <= cfg_data[DW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign dim_w = clamp_dim(grid_width_q);
	assign dim_h = clamp_dim(grid_height_q);
	assign dim_d = clamp_dim(grid_depth_q);

	// Drop addresses beyond the store
	assign addr_x    = XW'(cell_address);
	assign addr_ok   = (addr_x < XW'(CELLS));
	assign item_addr = AW'(addr_x);

	// Saturate the written value to the cell range
	assign wr_ext  = MW'(cell_value);
	assign wr_fits = (&wr_ext[MW-1:VALUE_BITS-1]) || !(|wr_ext[MW-1:VALUE_BITS-1]);

	always_comb begin
		if (wr_fits) begin
			wr_val = wr_ext[VALUE_BITS-1:0];
		end else if (wr_ext[MW-1]) begin
			wr_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			wr_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

	assign mem_wdata = mem_ctl.wsel_alu ? alu_result : wr_val;

	// Saturate a read cell to the output field
	assign rd_ext  = MW'(rdata);
	assign rd_fits = (&rd_ext[MW-1:hs3d_pkg::FIELD_W-1]) ||
		!(|rd_ext[MW-1:hs3d_pkg::FIELD_W-1]);

	always_comb begin
		if (rd_fits) begin
			rd_sat = rd_ext[hs3d_pkg::FIELD_W-1:0];
		end else if (rd_ext[MW-1]) begin
			rd_sat = {1'b1, {(hs3d_pkg::FIELD_W-1){1'b0}}};
		end else begin
			rd_sat = {1'b0, {(hs3d_pkg::FIELD_W-1){1'b1}}};
		end
	end

	hs3d_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.item_addr   (item_addr),
		.item_addr_ok(addr_ok),
		.time_steps  (time_steps_q),
		.dim_w       (dim_w),
		.dim_h       (dim_h),
		.dim_d       (dim_d),
		.out_free    (out_free),
		.mem_ctl     (mem_ctl),
		.raddr       (raddr),
		.waddr       (waddr),
		.alu_ctl     (alu_ctl),
		.out_ctl     (out_ctl)
	);

	hs3d_grid_mem #(
		.MAX_DIM   (MAX_DIM),
		.VALUE_BITS(VALUE_BITS)
	) u_grid_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.raddr(raddr),
		.waddr(waddr),
		.wdata(mem_wdata),
		.rdata(rdata)
	);

	hs3d_alu #(
		.VALUE_BITS(VALUE_BITS)
	) u_alu (
		.clk    (clk),
		.ctl    (alu_ctl),
		.alpha  (alpha_q),
		.rd_data(rdata),
		.result (alu_result)
	);

	// Output register: hold until the transaction completes
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ctl.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ctl.load) begin
			result_kind_q <= out_ctl.kind;
			read_value_q  <= out_ctl.zero ? '0 : rd_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign read_value  = read_value_q;

endmodule

[rtl/hs3d_grid_mem.sv]
module hs3d_grid_mem #(
	parameter int MAX_DIM    = hs3d_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = hs3d_pkg::VALUE_BITS_DEF
) (
	input  logic                                    clk,
	input  hs3d_pkg::mem_ctl_t                      ctl,
	input  logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] raddr,
	input  logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] waddr,
	input  logic [VALUE_BITS-1:0]                   wdata,
	output logic [VALUE_BITS-1:0]                   rdata
);

	localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;

	logic [VALUE_BITS-1:0] grid_a [CELLS];
	logic [VALUE_BITS-1:0] grid_b [CELLS];
	logic [VALUE_BITS-1:0] rd_a_q;
	logic [VALUE_BITS-1:0] rd_b_q;
	logic                  sel_b_q;

	// Write either buffer, read both at one address
	always_ff @(posedge clk) begin
		if (ctl.we_a) begin
			grid_a[waddr] <= wdata;
		end
		if (ctl.we_b) begin
			grid_b[waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_a_q  <= grid_a[raddr];
			rd_b_q  <= grid_b[raddr];
			sel_b_q <= ctl.rd_b;
		end
	end

	// Pick the buffer that was current at read time
	assign rdata = sel_b_q ? rd_b_q : rd_a_q;

endmodule

[rtl/hs3d_alu.sv]
module hs3d_alu #(
	parameter int VALUE_BITS = hs3d_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  hs3d_pkg::alu_ctl_t                  ctl,
	input  logic [hs3d_pkg::ALPHA_W-1:0]        alpha,
	input  logic signed [VALUE_BITS-1:0]        rd_data,
	output logic [VALUE_BITS-1:0]               result
);

	// Difference N - 6c fits in VALUE_BITS + 4, product adds the alpha bits and a sign
	localparam int DW = VALUE_BITS + 4;
	localparam int PW = DW + hs3d_pkg::ALPHA_W + 1;

	logic signed [PW-1:0]         acc_q;
	logic signed [DW-1:0]         d_q;
	logic signed [VALUE_BITS-1:0] c_q;
	logic signed [PW-1:0]         rd_ext;
	logic signed [PW-1:0]         d_ext;
	logic signed [PW-1:0]         c_ext;
	logic signed [PW-1:0]         sum;
	logic signed [PW-1:0]         rnd_one;
	logic                         sum_fits;

	assign rd_ext  = PW'(rd_data);
	assign d_ext   = PW'(d_q);
	assign c_ext   = PW'(c_q);
	assign rnd_one = PW'(1) <<< (hs3d_pkg::ALPHA_W - 1);

	// One centre load, accumulate, multiply setup, shift-add or round step per cycle; hold otherwise
	always_ff @(posedge clk) begin
		case (ctl.op)
			hs3d_pkg::ALU_CENTRE: begin
				c_q   <= rd_data;
				acc_q <= -((rd_ext <<< 2) + (rd_ext <<< 1));
			end
			hs3d_pkg::ALU_ADD: begin
				acc_q <= acc_q + rd_ext;
			end
			hs3d_pkg::ALU_MINIT: begin
				d_q   <= acc_q[DW-1:0];
				acc_q <= '0;
			end
			hs3d_pkg::ALU_MUL: begin
				acc_q <= (acc_q <<< 1) + (alpha[ctl.bit_idx] ? d_ext : PW'(0));
			end
			hs3d_pkg::ALU_RND: begin
				acc_q <= (acc_q + rnd_one) >>> hs3d_pkg::ALPHA_W;
			end
			default: begin
			end
		endcase
	end

	// Add the centre back and saturate to the cell range
	assign sum      = acc_q + c_ext;
	assign sum_fits = (&sum[PW-1:VALUE_BITS-1]) || !(|sum[PW-1:VALUE_BITS-1]);

	always_comb begin
		if (sum_fits) begin
			result = sum[VALUE_BITS-1:0];
		end else if (sum[PW-1]) begin
			result = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

endmodule

[rtl/hs3d_ctrl.sv]
module hs3d_ctrl #(
	parameter int MAX_DIM = hs3d_pkg::MAX_DIM_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [1:0]                                 opcode,
	input  logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] item_addr,
	input  logic                                       item_addr_ok,
	input  logic [hs3d_pkg::STEPS_W-1:0]               time_steps,
	input  logic [hs3d_pkg::DIM_W-1:0]                 dim_w,
	input  logic [hs3d_pkg::DIM_W-1:0]                 dim_h,
	input  logic [hs3d_pkg::DIM_W-1:0]                 dim_d,
	input  logic                                       out_free,
	output hs3d_pkg::mem_ctl_t                         mem_ctl,
	output logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] raddr,
	output logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] waddr,
	output hs3d_pkg::alu_ctl_t                         alu_ctl,
	output hs3d_pkg::out_ctl_t                         out_ctl
);

	localparam int AW     = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
	localparam int DW     = hs3d_pkg::DIM_W;
	localparam int IW_RAW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int IW     = (IW_RAW < DW) ? IW_RAW : DW;
	localparam logic [2:0] FETCH_LAST = 3'd6;

	hs3d_pkg::ctrl_state_t state_q, state_d;

	logic                               cur_b_q;
	logic                               rd_oor_q;
	logic [hs3d_pkg::STEPS_W-1:0]       steps_left_q;
	logic [AW-1:0]                      plane_q;
	logic [AW-1:0]                      c_q;
	logic [IW-1:0]                      i_q, j_q, k_q;
	logic [2:0]                         step_q;
	logic [hs3d_pkg::ALPHA_BIT_W-1:0]   mul_q;
	logic [2*DW-1:0]                    plane_full;
	logic [AW-1:0]                      w_a;
	logic                               accept;
	logic                               i_last, j_last, k_last, cell_last;
	logic [AW-1:0]                      fetch_addr;

	assign accept     = in_valid && (state_q == hs3d_pkg::ST_IDLE);
	assign in_stall   = (state_q != hs3d_pkg::ST_IDLE);
	assign plane_full = (2*DW)'(dim_w) * (2*DW)'(dim_h);
	assign w_a        = AW'(dim_w);
	assign k_last     = (DW'(k_q) == dim_w - DW'(1));
	assign j_last     = (DW'(j_q) == dim_h - DW'(1));
	assign i_last     = (DW'(i_q) == dim_d - DW'(1));
	assign cell_last  = i_last && j_last && k_last;

	// Seven reads per cell: centre, then the three axis pairs
	always_comb begin
		case (step_q)
			3'd0: fetch_addr = c_q;
			3'd1: fetch_addr = c_q - AW'(1);
			3'd2: fetch_addr = k_last ? c_q : c_q + AW'(1);
			3'd3: fetch_addr = c_q - w_a;
			3'd4: fetch_addr = j_last ? c_q : c_q + w_a;
			3'd5: fetch_addr = c_q - plane_q;
			3'd6: fetch_addr = i_last ? c_q : c_q + plane_q;
			default: fetch_addr = c_q;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hs3d_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						hs3d_pkg::OP_READ: state_d = hs3d_pkg::ST_RD;
						hs3d_pkg::OP_RUN:  state_d = hs3d_pkg::ST_SETUP;
						default:           state_d = hs3d_pkg::ST_IDLE;
					endcase
				end
			end
			hs3d_pkg::ST_RD: begin
				if (out_free) begin
					state_d = hs3d_pkg::ST_IDLE;
				end
			end
			hs3d_pkg::ST_SETUP: state_d = hs3d_pkg::ST_NEXT;
			hs3d_pkg::ST_NEXT: begin
				state_d = (steps_left_q == '0) ? hs3d_pkg::ST_DONE : hs3d_pkg::ST_FETCH;
			end
			hs3d_pkg::ST_FETCH: begin
				if (step_q == FETCH_LAST) begin
					state_d = hs3d_pkg::ST_LAST;
				end
			end
			hs3d_pkg::ST_LAST:  state_d = hs3d_pkg::ST_MINIT;
			hs3d_pkg::ST_MINIT: state_d = hs3d_pkg::ST_MUL;
			hs3d_pkg::ST_MUL: begin
				if (mul_q == '0) begin
					state_d = hs3d_pkg::ST_RND;
				end
			end
			hs3d_pkg::ST_RND: state_d = hs3d_pkg::ST_FIN;
			hs3d_pkg::ST_FIN: begin
				state_d = cell_last ? hs3d_pkg::ST_NEXT : hs3d_pkg::ST_FETCH;
			end
			hs3d_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = hs3d_pkg::ST_IDLE;
				end
			end
			default: state_d = hs3d_pkg::ST_IDLE;
		endcase
	end

	// Outputs per state
	always_comb begin
		mem_ctl         = '0;
		mem_ctl.rd_b    = cur_b_q;
		raddr           = fetch_addr;
		waddr           = c_q;
		alu_ctl.op      = hs3d_pkg::ALU_HOLD;
		alu_ctl.bit_idx = mul_q;
		out_ctl         = '0;
		case (state_q)
			hs3d_pkg::ST_IDLE: begin
				raddr = item_addr;
				waddr = item_addr;
				if (accept && opcode == hs3d_pkg::OP_WRITE && item_addr_ok) begin
					mem_ctl.we_a = 1'b1;
					mem_ctl.we_b = 1'b1;
				end
				if (accept && opcode == hs3d_pkg::OP_READ) begin
					mem_ctl.re = 1'b1;
				end
			end
			hs3d_pkg::ST_RD: begin
				out_ctl.load = out_free;
				out_ctl.kind = hs3d_pkg::KIND_READ;
				out_ctl.zero = rd_oor_q;
			end
			hs3d_pkg::ST_FETCH: begin
				mem_ctl.re = 1'b1;
				if (step_q == 3'd1) begin
					alu_ctl.op = hs3d_pkg::ALU_CENTRE;
				end else if (step_q != 3'd0) begin
					alu_ctl.op = hs3d_pkg::ALU_ADD;
				end
			end
			hs3d_pkg::ST_LAST:  alu_ctl.op = hs3d_pkg::ALU_ADD;
			hs3d_pkg::ST_MINIT: alu_ctl.op = hs3d_pkg::ALU_MINIT;
			hs3d_pkg::ST_MUL:   alu_ctl.op = hs3d_pkg::ALU_MUL;
			hs3d_pkg::ST_RND:   alu_ctl.op = hs3d_pkg::ALU_RND;
			hs3d_pkg::ST_FIN: begin
				mem_ctl.we_a     = cur_b_q;
				mem_ctl.we_b     = !cur_b_q;
				mem_ctl.wsel_alu = 1'b1;
			end
			hs3d_pkg::ST_DONE: begin
				out_ctl.load = out_free;
				out_ctl.kind = hs3d_pkg::KIND_DONE;
				out_ctl.zero = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State, sweep counters and cell walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hs3d_pkg::ST_IDLE;
			cur_b_q      <= 1'b0;
			rd_oor_q     <= 1'b0;
			steps_left_q <= '0;
			plane_q      <= '0;
			c_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			step_q       <= '0;
			mul_q        <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				hs3d_pkg::ST_IDLE: begin
					if (accept && opcode == hs3d_pkg::OP_READ) begin
						rd_oor_q <= !item_addr_ok;
					end
				end
				hs3d_pkg::ST_SETUP: begin
					plane_q      <= AW'(plane_full);
					steps_left_q <= time_steps;
				end
				hs3d_pkg::ST_NEXT: begin
					if (steps_left_q != '0) begin
						steps_left_q <= steps_left_q - 1'b1;
						i_q          <= IW'(1);
						j_q          <= IW'(1);
						k_q          <= IW'(1);
						c_q          <= plane_q + w_a + AW'(1);
						step_q       <= '0;
					end
				end
				hs3d_pkg::ST_FETCH: step_q <= step_q + 3'd1;
				hs3d_pkg::ST_MINIT: mul_q <= '1;
				hs3d_pkg::ST_MUL:   mul_q <= mul_q - 1'b1;
				hs3d_pkg::ST_FIN: begin
					step_q <= '0;
					// Advance along k, then wrap to the next row or plane
					if (!k_last) begin
						k_q <= k_q + IW'(1);
						c_q <= c_q + AW'(1);
					end else if (!j_last) begin
						j_q <= j_q + IW'(1);
						k_q <= IW'(1);
						c_q <= c_q + AW'(2);
					end else if (!i_last) begin
						i_q <= i_q + IW'(1);
						j_q <= IW'(1);
						k_q <= IW'(1);
						c_q <= c_q + w_a + AW'(2);
					end else begin
						cur_b_q <= !cur_b_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/hs3d_checker.sv]
module hs3d_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_we,
	input logic [hs3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [hs3d_pkg::CFG_W-1:0]           cfg_data,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic [1:0]                           opcode,
	input logic [hs3d_pkg::ADDR_W-1:0]          cell_address,
	input logic signed [hs3d_pkg::FIELD_W-1:0]  cell_value,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic                                 result_kind,
	input logic signed [hs3d_pkg::FIELD_W-1:0]  read_value
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(read_value))
		else $error("stalled result changed");

	// A run completion carries zero data
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hs3d_pkg::KIND_DONE |-> read_value == '0)
		else $error("completion with nonzero data");

	// A read or run transaction occupies the block in the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == hs3d_pkg::OP_READ || opcode == hs3d_pkg::OP_RUN)
		|=> in_stall)
		else $error("read or run did not occupy the block");

	// A write transaction leaves the block ready
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == hs3d_pkg::OP_WRITE |=> !in_stall)
		else $error("write stalled the next transaction");

	// No result right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind heat_stencil_3d_sweeper hs3d_checker u_hs3d_checker (.*);
